// ----- src/ebu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ebu_pkg;

   // Item kinds carried in req_tuser
   localparam logic CMD_ENC  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register indexes on the csr port
   localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [1:0] REG_LONGPRESS = 2'd1;
   localparam logic [1:0] REG_LOCKOUT   = 2'd2;
   localparam logic [1:0] REG_SHORTCUT  = 2'd3;

   // Event codes
   localparam logic [3:0] EV_CW      = 4'd0;
   localparam logic [3:0] EV_CCW     = 4'd1;
   localparam logic [3:0] EV_SHORT   = 4'd2;
   localparam logic [3:0] EV_LONG    = 4'd3;
   localparam logic [3:0] EV_PLAY    = 4'd4;
   localparam logic [3:0] EV_NEXT    = 4'd5;
   localparam logic [3:0] EV_PREV    = 4'd6;
   localparam logic [3:0] EV_MONITOR = 4'd7;
   localparam logic [3:0] EV_VOLUME  = 4'd8;
   localparam logic [3:0] EV_MEDIA   = 4'd9;
   localparam logic [3:0] EV_GALLERY = 4'd10;

   // Button lanes
   localparam int NUM_BTN    = 8;
   localparam int BTN_ENC    = 0;
   localparam int BTN_PLAY   = 1;
   localparam int BTN_SHORT0 = 4;
   localparam int NUM_MEDIA  = 3;

   // Event mask after the encoder steps: bit i carries code EV_SHORT + i
   localparam int EV_MASK_BITS = 9;
   localparam int MAX_OUT      = 16;

   localparam int DEB_W   = 10;
   localparam int HOLD_W  = 14;
   localparam int TIME_W  = 32;
   localparam int PEND_W  = 8;
   localparam int SUB_W   = 4;
   localparam int CSR_W   = 14;

   localparam logic signed [PEND_W-1:0] PEND_MAX = 8'sd127;
   localparam logic signed [SUB_W-1:0]  SUB_HI   = 4'sd3;
   localparam logic signed [SUB_W-1:0]  SUB_LO   = -4'sd3;

   // Quadrature step per {prev A, prev B, A, B}
   localparam logic signed [1:0] QUAD_TABLE [16] = '{
      2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
      -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
   };

   typedef struct packed {
      logic edge_hit;   // stable level changed on this tick
      logic stable;     // stable level after this tick, 1 = pressed
   } btn_status_type;

endpackage

`default_nettype wire

// ----- src/ebu_quad.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ebu_quad
   import ebu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     sample,
   input  wire logic                     enc_a,
   input  wire logic                     enc_b,
   input  wire logic                     tick,
   output      logic signed [PEND_W-1:0] pending
);

   logic [1:0]               prev_ab_ff;
   logic signed [SUB_W-1:0]  sub_ff, sub_in;
   logic signed [PEND_W-1:0] pend_ff, pend_in;
   logic signed [SUB_W-1:0]  sum;

   always_comb begin
      sum     = sub_ff + SUB_W'(QUAD_TABLE[{prev_ab_ff, enc_a, enc_b}]);
      sub_in  = sum;
      pend_in = pend_ff;
      if (sum > SUB_HI) begin
         sub_in = '0;
         if (pend_ff < PEND_MAX) pend_in = pend_ff + 1'b1;
      end else if (sum < SUB_LO) begin
         sub_in = '0;
         if (pend_ff > -PEND_MAX) pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff <= 2'b11;
         sub_ff     <= '0;
         pend_ff    <= '0;
      end else if (sample) begin
         prev_ab_ff <= {enc_a, enc_b};
         sub_ff     <= sub_in;
         pend_ff    <= pend_in;
      end else if (tick) begin
         pend_ff <= '0;
      end
   end

   assign pending = pend_ff;

endmodule

`default_nettype wire

// ----- src/ebu_debounce.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ebu_debounce
   import ebu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tick,
   input  wire logic              level,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire logic [DEB_W-1:0]  debounce_ms,
   output      btn_status_type    status
);

   logic              raw_last_ff;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] change_ff, change_in;
   logic              raw;
   logic              fire;

   always_comb begin
      raw       = ~level;
      change_in = (raw != raw_last_ff) ? now_ms : change_ff;
      fire      = ((now_ms - change_in) >= TIME_W'(debounce_ms)) && (stable_ff != raw);
      stable_in = fire ? raw : stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff <= 1'b0;
         stable_ff   <= 1'b0;
         change_ff   <= '0;
      end else if (tick) begin
         raw_last_ff <= raw;
         stable_ff   <= stable_in;
         change_ff   <= change_in;
      end
   end

   assign status.edge_hit = fire;
   assign status.stable   = stable_in;

endmodule

`default_nettype wire

// ----- src/ebu_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ebu_merge
   import ebu_pkg::*;
#(
   parameter int BURST_CAP = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tick,
   input  wire logic [TIME_W-1:0]        now_ms,
   input  wire logic signed [PEND_W-1:0] pending,
   input  wire btn_status_type           status [NUM_BTN],
   input  wire logic [HOLD_W-1:0]        hold_limit_ms,
   input  wire logic [HOLD_W-1:0]        repeat_lockout_ms,
   input  wire logic                     shortcut_enable,
   output      logic                     busy,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [3:0]               rsp_code,
   output      logic                     rsp_last
);

   localparam int MAG_W  = $clog2(BURST_CAP + 1);
   localparam int LEFT_W = $clog2(BURST_CAP + EV_MASK_BITS + 1);
   localparam int SENT_W = $clog2(MAX_OUT);
   localparam int IDX_W  = $clog2(EV_MASK_BITS);

   logic [TIME_W-1:0] press_ff, press_in;
   logic              long_rep_ff, long_rep_in;
   logic [TIME_W-1:0] fire_ff [NUM_MEDIA];
   logic [TIME_W-1:0] fire_in [NUM_MEDIA];

   logic                    job_dir_ff;
   logic [MAG_W-1:0]        job_steps_ff;
   logic [EV_MASK_BITS-1:0] job_mask_ff;
   logic [LEFT_W-1:0]       job_left_ff;
   logic [SENT_W-1:0]       job_sent_ff;

   logic                    out_valid_ff;
   logic [3:0]              out_code_ff;
   logic                    out_last_ff;

   logic [EV_MASK_BITS-1:0] mask;
   logic                    dir;
   logic [PEND_W-1:0]       mag_abs;
   logic [MAG_W-1:0]        mag;
   logic [LEFT_W-1:0]       total;
   logic                    pressed_edge;
   logic                    long_eff;
   logic [TIME_W-1:0]       hold_time;
   logic                    slot_free;
   logic                    emit;
   logic [IDX_W-1:0]        low_idx;
   logic [3:0]              emit_code;
   logic                    emit_last;

   // Gather what the lanes found into one event mask for this tick
   always_comb begin
      mask         = '0;
      press_in     = press_ff;
      long_rep_in  = long_rep_ff;
      pressed_edge = status[BTN_ENC].edge_hit && status[BTN_ENC].stable;
      if (status[BTN_ENC].edge_hit) begin
         if (status[BTN_ENC].stable) begin
            press_in    = now_ms;
            long_rep_in = 1'b0;
         end else if (!long_rep_ff) begin
            mask[0] = 1'b1;
         end
      end
      long_eff  = pressed_edge ? 1'b0 : long_rep_ff;
      hold_time = pressed_edge ? '0 : (now_ms - press_ff);
      if (status[BTN_ENC].stable && !long_eff && hold_time >= TIME_W'(hold_limit_ms)) begin
         long_rep_in = 1'b1;
         mask[1]     = 1'b1;
      end
      for (int i = 0; i < NUM_MEDIA; i++) begin
         fire_in[i] = fire_ff[i];
         if (status[BTN_PLAY + i].edge_hit && status[BTN_PLAY + i].stable &&
             (now_ms - fire_ff[i]) >= TIME_W'(repeat_lockout_ms)) begin
            fire_in[i]  = now_ms;
            mask[2 + i] = 1'b1;
         end
      end
      for (int i = 0; i < NUM_BTN - BTN_SHORT0; i++) begin
         mask[5 + i] = shortcut_enable && status[BTN_SHORT0 + i].edge_hit &&
                       status[BTN_SHORT0 + i].stable;
      end
   end

   // Burst cap on the pending detent steps
   always_comb begin
      dir     = pending[PEND_W-1];
      mag_abs = dir ? PEND_W'(-pending) : PEND_W'(pending);
      mag     = (mag_abs > PEND_W'(BURST_CAP)) ? MAG_W'(BURST_CAP) : mag_abs[MAG_W-1:0];
      total   = LEFT_W'(mag) + LEFT_W'($countones(mask));
   end

   always_comb begin
      low_idx = '0;
      for (int i = EV_MASK_BITS - 1; i >= 0; i--) begin
         if (job_mask_ff[i]) low_idx = IDX_W'(i);
      end
      slot_free = !out_valid_ff || rsp_ready;
      emit      = (job_left_ff != '0) && slot_free;
      if (job_steps_ff != '0) begin
         emit_code = job_dir_ff ? EV_CCW : EV_CW;
      end else begin
         emit_code = EV_SHORT + 4'(low_idx);
      end
      emit_last = (job_left_ff == LEFT_W'(1)) || (job_sent_ff == SENT_W'(MAX_OUT - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff    <= '0;
         long_rep_ff <= 1'b0;
         for (int i = 0; i < NUM_MEDIA; i++) fire_ff[i] <= '0;
      end else if (tick) begin
         press_ff    <= press_in;
         long_rep_ff <= long_rep_in;
         for (int i = 0; i < NUM_MEDIA; i++) fire_ff[i] <= fire_in[i];
      end
   end

   // Job: the events of one tick, drained one per cycle into the output register while it has room
   always_ff @(posedge clock) begin
      if (reset) begin
         job_left_ff  <= '0;
         job_steps_ff <= '0;
         job_mask_ff  <= '0;
         job_sent_ff  <= '0;
         job_dir_ff   <= 1'b0;
      end else if (tick) begin
         job_left_ff  <= total;
         job_steps_ff <= mag;
         job_mask_ff  <= mask;
         job_sent_ff  <= '0;
         job_dir_ff   <= dir;
      end else if (emit) begin
         job_left_ff <= emit_last ? '0 : job_left_ff - 1'b1;
         job_sent_ff <= job_sent_ff + 1'b1;
         if (job_steps_ff != '0) begin
            job_steps_ff <= job_steps_ff - 1'b1;
         end else begin
            job_mask_ff[low_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_code_ff <= '0;
         out_last_ff <= 1'b0;
      end else if (emit) begin
         out_code_ff <= emit_code;
         out_last_ff <= emit_last;
      end
   end

   assign busy      = (job_left_ff != '0);
   assign rsp_valid = out_valid_ff;
   assign rsp_code  = out_code_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

// ----- src/encoder_and_button_event_unit_top.sv -----
// Encoder samples: one item per cycle, no result; the step count is ready in the following cycle.
// Poll tick: taken when no event job is busy; events go via the job and output registers,
// one per cycle while the sink is ready. The next tick is held off while the job drains.
// Reset: synchronous, active high; all state and registers return to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module encoder_and_button_event_unit_top
   import ebu_pkg::*;
#(
   parameter int BURST_CAP = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   // [0] enc_a, [1] enc_b, [33:2] now_ms, [34] enc_button_level, [35] play_level,
   // [36] next_level, [37] prev_level, [38] monitor_level, [39] volume_level,
   // [40] media_level, [41] gallery_level, [47:42] zero
   input  wire logic [47:0]       req_tdata,
   // [0] command
   input  wire logic              req_tuser,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   // [3:0] event_code, [7:4] zero
   output      logic [7:0]        rsp_tdata,
   output      logic              rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   logic [DEB_W-1:0]  debounce_ff;
   logic [HOLD_W-1:0] longpress_ff;
   logic [HOLD_W-1:0] lockout_ff;
   logic              shortcut_ff;

   logic                     busy;
   logic                     accept;
   logic                     sample;
   logic                     tick;
   logic [TIME_W-1:0]        now_ms;
   logic [NUM_BTN-1:0]       levels;
   logic signed [PEND_W-1:0] pending;
   btn_status_type           status [NUM_BTN];
   logic [3:0]               code;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEB_W'(20);
         longpress_ff <= HOLD_W'(600);
         lockout_ff   <= HOLD_W'(250);
         shortcut_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE:  debounce_ff  <= csr_wdata[DEB_W-1:0];
            REG_LONGPRESS: longpress_ff <= csr_wdata;
            REG_LOCKOUT:   lockout_ff   <= csr_wdata;
            REG_SHORTCUT:  shortcut_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Encoder samples pass even while a tick's events are still draining
   assign req_tready = !busy || (req_tuser == CMD_ENC);
   assign accept     = req_tvalid && req_tready;
   assign sample     = accept && (req_tuser == CMD_ENC);
   assign tick       = accept && (req_tuser == CMD_TICK);
   assign now_ms     = req_tdata[33:2];
   assign levels     = req_tdata[41:34];

   ebu_quad u_quad (
      .clock   (clock),
      .reset   (reset),
      .sample  (sample),
      .enc_a   (req_tdata[0]),
      .enc_b   (req_tdata[1]),
      .tick    (tick),
      .pending (pending)
   );

   for (genvar g = 0; g < NUM_BTN; g++) begin : g_lane
      ebu_debounce u_lane (
         .clock       (clock),
         .reset       (reset),
         .tick        (tick),
         .level       (levels[g]),
         .now_ms      (now_ms),
         .debounce_ms (debounce_ff),
         .status      (status[g])
      );
   end

   ebu_merge #(
      .BURST_CAP (BURST_CAP)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .tick              (tick),
      .now_ms            (now_ms),
      .pending           (pending),
      .status            (status),
      .hold_limit_ms     (longpress_ff),
      .repeat_lockout_ms (lockout_ff),
      .shortcut_enable   (shortcut_ff),
      .busy              (busy),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_code          (code),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, code};

endmodule

`default_nettype wire

// ----- sim/tb_encoder_and_button_event_unit_top.sv -----
`timescale 1ns / 1ps

module tb_encoder_and_button_event_unit_top;
   import ebu_pkg::*;

   localparam int STEP_CAP = 8;
   localparam int QSTEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
   localparam logic [1:0] REG_ORDER [4] = '{REG_DEBOUNCE, REG_LONGPRESS, REG_LOCKOUT,
                                             REG_SHORTCUT};

   typedef struct packed {
      logic        cmd;
      logic        a;
      logic        b;
      logic [31:0] now;
      logic [7:0]  lv;     // bit i = pin level of button lane i, 0 = pressed
   } item_type;

   typedef struct packed {
      logic [3:0] code;
      logic       last;
   } ev_type;

   typedef struct packed {
      item_type   it;
      logic       chk;
      logic [4:0] n_exp;
      logic [3:0] code;
   } row_type;

   // Directed items; where chk is set, the event count and first code are typed in
   localparam row_type PLAN [25] = '{
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd0,    8'hFF}, 1'b1, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b1, 1'b1, 32'd5,    8'hFD}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd30,   8'hFD}, 1'b1, 5'd0, EV_CW},   // inside lockout
      '{'{CMD_TICK, 1'b0, 1'b1, 32'd40,   8'hFF}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b1, 1'b0, 32'd300,  8'hFF}, 1'b1, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd310,  8'hFD}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd330,  8'hFD}, 1'b1, 5'd1, EV_PLAY},
      '{'{CMD_ENC,  1'b0, 1'b1, 32'hFFFF_FFFF, 8'h00}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_ENC,  1'b0, 1'b0, 32'd0,    8'hFF}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_ENC,  1'b1, 1'b0, 32'h5555_5555, 8'hAA}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_ENC,  1'b1, 1'b1, 32'hAAAA_AAAA, 8'h55}, 1'b1, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b1, 1'b1, 32'd340,  8'hFE}, 1'b1, 5'd1, EV_CW},
      '{'{CMD_ENC,  1'b0, 1'b0, 32'd7,    8'h00}, 1'b0, 5'd0, EV_CW},   // double jump
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd360,  8'hFE}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd960,  8'hFE}, 1'b1, 5'd1, EV_LONG},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd970,  8'hFF}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd990,  8'hFF}, 1'b1, 5'd0, EV_CW},   // no short after long
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd1000, 8'hFE}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd1020, 8'hFE}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd1025, 8'hFF}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd1045, 8'hFF}, 1'b1, 5'd1, EV_SHORT},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd1050, 8'h0F}, 1'b0, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd1070, 8'h0F}, 1'b1, 5'd4, EV_MONITOR},
      '{'{CMD_TICK, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'h00}, 1'b1, 5'd0, EV_CW},
      '{'{CMD_TICK, 1'b0, 1'b0, 32'd0,    8'hFF}, 1'b0, 5'd0, EV_CW}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [47:0]       req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   // predicted block state
   logic [1:0]          pr_ab = 2'b11;
   int                  pr_sub = 0;
   int                  pr_pend = 0;
   logic [NUM_BTN-1:0]  pr_stable = '0;
   logic [NUM_BTN-1:0]  pr_raw = '0;
   logic [31:0]         pr_chg [NUM_BTN] = '{default: '0};
   logic [31:0]         pr_fire [NUM_MEDIA] = '{default: '0};
   logic [31:0]         pr_hold_start = '0;
   logic                pr_long_done = 1'b0;
   logic [9:0]          cf_debounce = 10'd20;
   logic [13:0]         cf_longpress = 14'd600;
   logic [13:0]         cf_lockout = 14'd250;
   logic                cf_shortcut = 1'b1;

   ev_type              due_events [$];
   int                  fail_count = 0;
   bit                  idle_on = 1'b0;
   bit                  hold_off_req = 1'b0;
   logic [1:0]          pin_ab = 2'b11;
   logic [31:0]         clk_ms = '0;
   logic [7:0]          btn_lv = 8'hFF;
   int                  items_sent = 0;

   encoder_and_button_event_unit_top #(.BURST_CAP(STEP_CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void note_error(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Updates the predicted state for one item and queues the events it yields
   function automatic int compute_events(item_type it);
      logic [3:0]         code;
      logic [3:0]         evs [$];
      logic [NUM_BTN-1:0] hit;
      logic [31:0]        dt;
      logic               raw;
      int                 steps;
      int                 k;
      if (it.cmd == CMD_ENC) begin
         code = {pr_ab, it.a, it.b};
         pr_ab = {it.a, it.b};
         pr_sub += QSTEP[code];
         if (pr_sub > 3) begin
            if (pr_pend < 127) pr_pend++;
            pr_sub = 0;
         end else if (pr_sub < -3) begin
            if (pr_pend > -127) pr_pend--;
            pr_sub = 0;
         end
         return 0;
      end
      // detent steps go out first; whatever exceeds the cap is lost
      steps = pr_pend;
      pr_pend = 0;
      if (steps > STEP_CAP) steps = STEP_CAP;
      if (steps < -STEP_CAP) steps = -STEP_CAP;
      for (k = 0; k < steps; k++) evs.push_back(EV_CW);
      for (k = 0; k < -steps; k++) evs.push_back(EV_CCW);
      for (k = 0; k < NUM_BTN; k++) begin
         raw = !it.lv[k];
         if (raw != pr_raw[k]) begin
            pr_raw[k] = raw;
            pr_chg[k] = it.now;
         end
         dt = it.now - pr_chg[k];
         hit[k] = (dt >= cf_debounce) && (pr_stable[k] != raw);
         if (hit[k]) pr_stable[k] = raw;
      end
      if (hit[BTN_ENC]) begin
         if (pr_stable[BTN_ENC]) begin
            pr_hold_start = it.now;
            pr_long_done = 1'b0;
         end else if (!pr_long_done) begin
            evs.push_back(EV_SHORT);
         end
      end
      dt = it.now - pr_hold_start;
      if (pr_stable[BTN_ENC] && !pr_long_done && dt >= cf_longpress) begin
         pr_long_done = 1'b1;
         evs.push_back(EV_LONG);
      end
      for (k = 0; k < NUM_MEDIA; k++) begin
         dt = it.now - pr_fire[k];
         if (hit[BTN_PLAY + k] && pr_stable[BTN_PLAY + k] && dt >= cf_lockout) begin
            pr_fire[k] = it.now;
            evs.push_back(4'(EV_PLAY + k));
         end
      end
      if (cf_shortcut) begin
         for (k = BTN_SHORT0; k < NUM_BTN; k++)
            if (hit[k] && pr_stable[k]) evs.push_back(4'(EV_MONITOR + k - BTN_SHORT0));
      end
      while (evs.size() > MAX_OUT) void'(evs.pop_back());
      foreach (evs[j]) due_events.push_back('{code: evs[j], last: (j == evs.size() - 1)});
      return evs.size();
   endfunction

   task automatic send_item(input item_type it, output int n, output logic [3:0] fc);
      int g;
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, it.lv, it.now, it.b, it.a};
      req_tuser <= it.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (it.cmd == CMD_ENC) pin_ab = {it.a, it.b};
      n = compute_events(it);
      fc = (n > 0) ? due_events[due_events.size() - n].code : EV_CW;
      g = idle_on ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Drain everything, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_regs(input logic [13:0] v0, v1, v2, v3);
      logic [13:0] v [4];
      int          k;
      v = '{v0, v1, v2, v3};
      for (k = 0; k < 4; k++) begin
         csr_we <= 1'b1;
         csr_index <= REG_ORDER[k];
         csr_wdata <= v[k];
         @(posedge clock);
         case (REG_ORDER[k])
            REG_DEBOUNCE:  cf_debounce = v[k][9:0];
            REG_LONGPRESS: cf_longpress = v[k];
            REG_LOCKOUT:   cf_lockout = v[k];
            REG_SHORTCUT:  cf_shortcut = v[k][0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // Quadrature walk of whole detents; noise_pct of the samples are random pins
   task automatic spin(input int detents, input bit cw, input int noise_pct);
      item_type   it;
      int         n;
      logic [3:0] fc;
      int         k;
      for (k = 0; k < 4 * detents; k++) begin
         it.cmd = CMD_ENC;
         if ($urandom_range(0, 99) < noise_pct) begin
            {it.a, it.b} = 2'($urandom_range(0, 3));
         end else begin
            case (pin_ab)
               2'b11:   {it.a, it.b} = cw ? 2'b01 : 2'b10;
               2'b01:   {it.a, it.b} = cw ? 2'b00 : 2'b11;
               2'b00:   {it.a, it.b} = cw ? 2'b10 : 2'b01;
               default: {it.a, it.b} = cw ? 2'b11 : 2'b00;
            endcase
         end
         it.now = $urandom;
         it.lv = 8'($urandom_range(0, 255));
         send_item(it, n, fc);
      end
   endtask

   task automatic send_tick();
      item_type   it;
      int         n;
      logic [3:0] fc;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 60) clk_ms += $urandom_range(0, 40);
      else if (r < 90) clk_ms += $urandom_range(0, 700);
      else if (r < 98) clk_ms += $urandom_range(0, 12000);
      else clk_ms = $urandom;
      r = $urandom_range(0, 99);
      if (r < 35) btn_lv[$urandom_range(0, 7)] ^= 1'b1;
      else if (r < 40) btn_lv = 8'($urandom_range(0, 255));
      it.cmd = CMD_TICK;
      {it.a, it.b} = 2'($urandom_range(0, 3));
      it.now = clk_ms;
      it.lv = btn_lv;
      send_item(it, n, fc);
   endtask

   task automatic random_mix(input int count);
      int target;
      int r;
      target = items_sent + count;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 55) spin($urandom_range(0, 3), 1'($urandom_range(0, 1)), 10);
         else if (r < 95) send_tick();
         else spin(1, 1'b1, 100);
      end
   endtask

   initial begin : stim
      int         i;
      int         ph;
      int         k;
      int         n;
      logic [3:0] fc;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_ENC;
      csr_we <= 1'b0;
      csr_index <= REG_DEBOUNCE;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      for (i = 0; i < 25; i++) begin
         send_item(PLAN[i].it, n, fc);
         if (PLAN[i].chk && (n != PLAN[i].n_exp || (n > 0 && fc != PLAN[i].code)))
            note_error($sformatf("plan row %0d: expected %0d events first %0d, got %0d first %0d",
                                 i, PLAN[i].n_exp, PLAN[i].code, n, fc));
      end
      clk_ms = '0;
      btn_lv = 8'hFF;

      for (ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: write_regs(14'd0, 14'd0, 14'd0, 14'd0);
            1: write_regs(14'd1000, 14'd10000, 14'd10000, 14'd1);
            2: write_regs(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFE);   // debounce and shortcut keep only their low bits
            3: write_regs(14'd20, 14'd600, 14'd250, 14'd1);
            default: write_regs(14'($urandom_range(0, 1000)), 14'($urandom_range(0, 10000)),
                                14'($urandom_range(0, 10000)), 14'($urandom_range(0, 1)));
         endcase
         idle_on = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (ph == 0) begin
            // back-to-back full bursts while the sink holds off
            hold_off_req = 1'b1;
            for (k = 0; k < 4; k++) begin
               spin(8, 1'b1, 0);
               send_tick();
            end
         end
         if (ph == 3) begin
            // steps past the burst cap are dropped, both ways
            spin(12, 1'b1, 0);
            send_tick();
            spin(12, 1'b0, 0);
            send_tick();
         end
         random_mix(25);
      end

      settle();
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin : sink
      int k;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            k = 400;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            k = gap_len() + 1;
         end else begin
            rsp_tready <= 1'b1;
            k = idle_on ? $urandom_range(1, 6) : 1;
         end
         repeat (k) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      ev_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_events.size() == 0) begin
            note_error($sformatf("unexpected item: code %0d last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = due_events.pop_front();
            if (rsp_tdata !== {4'b0, want.code} || rsp_tlast !== want.last)
               note_error($sformatf("expected code %0d last %0b, got code %0d last %0b",
                                    want.code, want.last, rsp_tdata, rsp_tlast));
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
